### design/cbs_pkg.sv
package cbs_pkg;

   // Default datapath geometry
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Sample count register
   localparam int                  CNT_BITS        = 6;
   localparam logic [CNT_BITS-1:0] SAMPLES_RESET   = 6'd20;
   localparam logic [CNT_BITS-1:0] DEFAULT_SAMPLES = 6'd20;
   localparam logic [CNT_BITS-1:0] MAX_SAMPLES     = 6'd62;

   // de Casteljau steps, one lerp each
   localparam int               STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] STEP_P01 = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_P12 = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_P23 = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_Q01 = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_Q12 = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_R01 = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FINAL = 5'b00010,
      S_START = 5'b00100,
      S_CALC  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } tgen_ctl_type;

endpackage

### design/cbs_req_if.sv
interface cbs_req_if #(parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         final_point;

   modport source(output valid, output point_x, output point_y, output final_point,
                  input ready);
   modport sink(input valid, input point_x, input point_y, input final_point,
                output ready);
endinterface

### design/cbs_rsp_if.sv
interface cbs_rsp_if #(parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] curve_x;
   logic signed [COORD_BITS-1:0] curve_y;
   logic                         run_end;

   modport source(output valid, output curve_x, output curve_y, output run_end,
                  input ready);
   modport sink(input valid, input curve_x, input curve_y, input run_end,
                output ready);
endinterface

### design/cbs_lerp.sv
module cbs_lerp #(
   parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = cbs_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] a,
   input  logic signed [COORD_BITS-1:0] b,
   input  logic [FRAC_BITS-1:0]         t,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] y
);
   import cbs_pkg::*;

   localparam int C = COORD_BITS;
   localparam int F = FRAC_BITS;
   localparam logic [C+F:0]   HALF  = (C+F+1)'(1) << (F-1);
   localparam logic [C-1:0]   SMAX  = {1'b0, {(C-1){1'b1}}};
   localparam logic [C-1:0]   SMIN  = {1'b1, {(C-1){1'b0}}};

   logic signed [C:0]   d_ff;
   logic signed [C-1:0] a_ff;
   logic [F-1:0]        t_ff;
   logic                neg_ff;
   logic [C:0]          mag_ff;
   logic [C+F:0]        prod_ff;
   logic [C:0]          r_ff;
   logic signed [C-1:0] y_ff;
   logic [3:0]          v_ff;
   logic                done_ff;

   logic [C+F:0] rnd;
   logic [C+1:0] ext_a;
   logic [C+1:0] ext_r;
   logic [C+1:0] sum;
   logic [C-1:0] sat;

   always_comb begin
      rnd   = prod_ff + HALF;
      ext_a = {a_ff[C-1], a_ff[C-1], a_ff};
      ext_r = {1'b0, r_ff};
      sum   = neg_ff ? (ext_a - ext_r) : (ext_a + ext_r);
      if ((sum[C+1:C-1] == 3'b000) || (sum[C+1:C-1] == 3'b111)) begin
         sat = sum[C-1:0];
      end else if (sum[C+1]) begin
         sat = SMIN;
      end else begin
         sat = SMAX;
      end
   end

   // Control: walk a lerp down the stages; the caller must keep one lerp in flight, not enforced here
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         done_ff <= 1'b0;
      end else begin
         v_ff    <= {v_ff[2:0], start};
         done_ff <= v_ff[3];
      end
   end

   // Datapath: difference, magnitude, product, round, add and clamp
   always_ff @(posedge clock) begin
      if (start) begin
         d_ff <= $signed({b[C-1], b}) - $signed({a[C-1], a});
         a_ff <= a;
         t_ff <= t;
      end
      if (v_ff[0]) begin
         neg_ff <= d_ff[C];
         mag_ff <= d_ff[C] ? $unsigned(-d_ff) : $unsigned(d_ff);
      end
      if (v_ff[1]) begin
         prod_ff <= (C+F+1)'(mag_ff) * (C+F+1)'(t_ff);
      end
      if (v_ff[2]) begin
         r_ff <= rnd[C+F:F];
      end
      if (v_ff[3]) begin
         y_ff <= $signed(sat);
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

### design/cbs_tgen.sv
module cbs_tgen #(
   parameter int FRAC_BITS = cbs_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  cbs_pkg::tgen_ctl_type         ctl,
   input  logic [cbs_pkg::CNT_BITS-1:0]  n,
   output logic [FRAC_BITS-1:0]          t,
   output logic                          last
);
   import cbs_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int TAB = 1 << CNT_BITS;

   // Per-step increment of t = round(k * 2^F / n): quotient and remainder of 2^F / n
   logic [F:0]          quo_tab [TAB];
   logic [CNT_BITS-1:0] rem_tab [TAB];

   for (genvar g = 0; g < TAB; g++) begin : g_tab
      localparam int unsigned DIV = (g == 0) ? 1 : g;
      localparam int unsigned QV  = (1 << F) / DIV;
      localparam int unsigned RV  = (1 << F) % DIV;
      assign quo_tab[g] = (F+1)'(QV);
      assign rem_tab[g] = CNT_BITS'(RV);
   end

   logic [F-1:0]        t_ff;
   logic [CNT_BITS-1:0] rem_ff;
   logic [CNT_BITS-1:0] k_ff;

   logic [CNT_BITS:0]   r_add;
   logic                wrap;
   logic [F:0]          t_next;
   logic [CNT_BITS:0]   r_next;

   always_comb begin
      r_add  = {1'b0, rem_ff} + {1'b0, rem_tab[n]};
      wrap   = (r_add >= {1'b0, n});
      t_next = {1'b0, t_ff} + quo_tab[n] + (F+1)'(wrap);
      r_next = wrap ? (r_add - {1'b0, n}) : r_add;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         t_ff   <= '0;
         rem_ff <= n >> 1;
         k_ff   <= '0;
      end else if (ctl.advance) begin
         t_ff   <= t_next[F-1:0];
         rem_ff <= r_next[CNT_BITS-1:0];
         k_ff   <= k_ff + 1'b1;
      end
   end

   assign t    = t_ff;
   assign last = (k_ff == (n - 1'b1));

endmodule

### design/cubic_bezier_sampler.sv
// Channel   Direction  Transaction carries
// req_if    in         point_x, point_y (Q16.16), final_point
// rsp_if    out        curve_x, curve_y (Q16.16), run_end
// csr_*     in         samples_per_segment N (6 bits), written when csr_we is high
//
// A point not closing a segment is taken in idle, then S_FINAL if it ends the chain.
// For a point closing a segment, each sample runs twelve lerps (six per axis)
// one after another through the single five-stage lerp unit.
// Reset clears the sequencer, the chain state and N (back to 20); no clearing pass.
// The response register frees once rsp_if.ready is seen; a stall there holds the sequencer
// at its next output, and req_if.ready stays low until the block is back in idle.
module cubic_bezier_sampler #(
   parameter int COORD_BITS = cbs_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = cbs_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [cbs_pkg::CNT_BITS-1:0] csr_wdata,
   cbs_req_if.sink                      req_if,
   cbs_rsp_if.source                    rsp_if
);
   import cbs_pkg::*;

   localparam int C = COORD_BITS;

   // ---------------------------------------------------------------- state
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   nreg_ff;

   // Segment held so far: start point and two inner control points
   logic signed [C-1:0]   held_x_ff [3];
   logic signed [C-1:0]   held_y_ff [3];
   logic signed [C-1:0]   held_x_in [3];
   logic signed [C-1:0]   held_y_in [3];
   logic [1:0]            phase_ff, phase_in;
   logic                  started_ff, started_in;

   // The point of the current transaction
   logic signed [C-1:0]   in_x_ff, in_x_in;
   logic signed [C-1:0]   in_y_ff, in_y_in;
   logic                  fin_ff, fin_in;

   // Last point sent in this chain
   logic signed [C-1:0]   sent_x_ff, sent_x_in;
   logic signed [C-1:0]   sent_y_ff, sent_y_in;
   logic                  any_sent_ff, any_sent_in;

   // de Casteljau scratch and the finished sample
   logic signed [C-1:0]   w_ff [3];
   logic signed [C-1:0]   w_in [3];
   logic signed [C-1:0]   samp_x_ff, samp_x_in;
   logic signed [C-1:0]   samp_y_ff, samp_y_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  coord_ff, coord_in;
   logic                  busy_ff, busy_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0]   rsp_x_ff, rsp_x_in;
   logic signed [C-1:0]   rsp_y_ff, rsp_y_in;
   logic                  rsp_end_ff, rsp_end_in;

   // ---------------------------------------------------------------- shared units
   logic [CNT_BITS-1:0]   n_eff;
   tgen_ctl_type          tctl;
   logic [FRAC_BITS-1:0]  t_cur;
   logic                  t_last;

   logic                  lerp_start;
   logic                  lerp_done;
   logic signed [C-1:0]   op_a, op_b, lerp_y;
   logic signed [C-1:0]   pt [4];

   // N of zero means the default, anything past the maximum clamps
   always_comb begin
      if (nreg_ff == '0) begin
         n_eff = DEFAULT_SAMPLES;
      end else if (nreg_ff > MAX_SAMPLES) begin
         n_eff = MAX_SAMPLES;
      end else begin
         n_eff = nreg_ff;
      end
   end

   cbs_tgen #(.FRAC_BITS(FRAC_BITS)) u_tgen (
      .clock (clock),
      .ctl   (tctl),
      .n     (n_eff),
      .t     (t_cur),
      .last  (t_last)
   );

   cbs_lerp #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start),
      .a     (op_a),
      .b     (op_b),
      .t     (t_cur),
      .done  (lerp_done),
      .y     (lerp_y)
   );

   // Operand selection: the four control points of the axis in hand, then scratch
   always_comb begin
      pt[0] = coord_ff ? held_y_ff[0] : held_x_ff[0];
      pt[1] = coord_ff ? held_y_ff[1] : held_x_ff[1];
      pt[2] = coord_ff ? held_y_ff[2] : held_x_ff[2];
      pt[3] = coord_ff ? in_y_ff      : in_x_ff;
      case (step_ff)
         STEP_P01: begin
            op_a = pt[0];
            op_b = pt[1];
         end
         STEP_P12: begin
            op_a = pt[1];
            op_b = pt[2];
         end
         STEP_P23: begin
            op_a = pt[2];
            op_b = pt[3];
         end
         STEP_Q01: begin
            op_a = w_ff[0];
            op_b = w_ff[1];
         end
         STEP_Q12: begin
            op_a = w_ff[1];
            op_b = w_ff[2];
         end
         default: begin
            op_a = w_ff[0];
            op_b = w_ff[1];
         end
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   logic slot_free;
   logic final_differs;
   logic samp_differs;

   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign final_differs = (sent_x_ff != in_x_ff) || (sent_y_ff != in_y_ff);
   assign samp_differs  = (samp_x_ff != in_x_ff) || (samp_y_ff != in_y_ff);

   always_comb begin
      state_in     = state_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      phase_in     = phase_ff;
      started_in   = started_ff;
      in_x_in      = in_x_ff;
      in_y_in      = in_y_ff;
      fin_in       = fin_ff;
      sent_x_in    = sent_x_ff;
      sent_y_in    = sent_y_ff;
      any_sent_in  = any_sent_ff;
      w_in         = w_ff;
      samp_x_in    = samp_x_ff;
      samp_y_in    = samp_y_ff;
      step_in      = step_ff;
      coord_in     = coord_ff;
      busy_in      = busy_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      tctl         = '0;
      lerp_start   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               in_x_in = req_if.point_x;
               in_y_in = req_if.point_y;
               fin_in  = req_if.final_point;
               if (!started_ff) begin
                  // first point of a chain
                  held_x_in[0] = req_if.point_x;
                  held_y_in[0] = req_if.point_y;
                  phase_in     = 2'd1;
                  started_in   = 1'b1;
                  any_sent_in  = 1'b0;
               end else if (phase_ff != 2'd3) begin
                  held_x_in[phase_ff] = req_if.point_x;
                  held_y_in[phase_ff] = req_if.point_y;
                  phase_in            = phase_ff + 2'd1;
               end
               if (started_ff && (phase_ff == 2'd3)) begin
                  state_in = S_START;
               end else if (req_if.final_point) begin
                  // drop any partial segment and end the chain
                  started_in = 1'b0;
                  phase_in   = 2'd0;
                  state_in   = S_FINAL;
               end
            end
         end

         S_FINAL: begin
            if (!any_sent_ff || final_differs) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = in_x_ff;
                  rsp_y_in     = in_y_ff;
                  rsp_end_in   = 1'b1;
                  sent_x_in    = in_x_ff;
                  sent_y_in    = in_y_ff;
                  any_sent_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         S_START: begin
            if (slot_free) begin
               // segment start point goes out first, samples always follow
               rsp_valid_in = 1'b1;
               rsp_x_in     = held_x_ff[0];
               rsp_y_in     = held_y_ff[0];
               rsp_end_in   = 1'b0;
               sent_x_in    = held_x_ff[0];
               sent_y_in    = held_y_ff[0];
               any_sent_in  = 1'b1;
               tctl.load    = 1'b1;
               step_in      = STEP_P01;
               coord_in     = 1'b0;
               busy_in      = 1'b0;
               state_in     = S_CALC;
            end
         end

         S_CALC: begin
            if (!busy_ff) begin
               lerp_start = 1'b1;
               busy_in    = 1'b1;
            end else if (lerp_done) begin
               busy_in = 1'b0;
               if (step_ff == STEP_R01) begin
                  step_in = STEP_P01;
                  if (!coord_ff) begin
                     samp_x_in = lerp_y;
                     coord_in  = 1'b1;
                  end else begin
                     samp_y_in = lerp_y;
                     coord_in  = 1'b0;
                     state_in  = S_EMIT;
                  end
               end else begin
                  case (step_ff)
                     STEP_P01, STEP_Q01: w_in[0] = lerp_y;
                     STEP_P12, STEP_Q12: w_in[1] = lerp_y;
                     default:            w_in[2] = lerp_y;
                  endcase
                  step_in = step_ff + 1'b1;
               end
            end
         end

         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = samp_x_ff;
               rsp_y_in     = samp_y_ff;
               // last sample closes the run unless the final point must follow
               rsp_end_in   = t_last && !(fin_ff && samp_differs);
               sent_x_in    = samp_x_ff;
               sent_y_in    = samp_y_ff;
               any_sent_in  = 1'b1;
               if (t_last) begin
                  held_x_in[0] = in_x_ff;
                  held_y_in[0] = in_y_ff;
                  phase_in     = 2'd1;
                  if (fin_ff) begin
                     started_in = 1'b0;
                     phase_in   = 2'd0;
                     state_in   = S_FINAL;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  tctl.advance = 1'b1;
                  state_in     = S_CALC;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nreg_ff      <= SAMPLES_RESET;
         phase_ff     <= 2'd0;
         started_ff   <= 1'b0;
         any_sent_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_P01;
         coord_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         started_ff   <= started_in;
         any_sent_ff  <= any_sent_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         coord_ff     <= coord_in;
         if (csr_we) begin
            nreg_ff <= csr_wdata;
         end
      end
   end

   // Payload, no reset needed: every field is written before it is read
   always_ff @(posedge clock) begin
      held_x_ff  <= held_x_in;
      held_y_ff  <= held_y_in;
      in_x_ff    <= in_x_in;
      in_y_ff    <= in_y_in;
      fin_ff     <= fin_in;
      sent_x_ff  <= sent_x_in;
      sent_y_ff  <= sent_y_in;
      w_ff       <= w_in;
      samp_x_ff  <= samp_x_in;
      samp_y_ff  <= samp_y_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_end_ff <= rsp_end_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.curve_x = rsp_x_ff;
   assign rsp_if.curve_y = rsp_y_ff;
   assign rsp_if.run_end = rsp_end_ff;

endmodule

### tb/tb_cubic_bezier_sampler.sv
`timescale 1ns / 100ps

module tb_cubic_bezier_sampler;
   import cbs_pkg::*;

   localparam int CW             = COORD_BITS_DEF;
   localparam int FW             = FRAC_BITS_DEF;
   localparam int ITEM_TARGET    = 450;
   localparam int SETTLE_CYCLES  = 8;    // lets a chain-ending point without output get back to idle
   localparam int DRAIN_CYCLES   = 50;
   localparam int WATCHDOG_LIMIT = 2000; // covers the gap between curve points plus a result stall

   localparam longint FRAC_MASK = (64'sd1 <<< FW) - 1;
   localparam longint ROUND_BIT = 64'sd1 <<< (FW - 1);
   localparam longint COORD_HI  = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint COORD_LO  = -COORD_HI - 1;

   typedef logic signed [CW-1:0] coord_t;

   localparam coord_t COORD_MAX = coord_t'(COORD_HI);
   localparam coord_t COORD_MIN = coord_t'(COORD_LO);

   typedef struct packed {
      coord_t x;
      coord_t y;
      logic   run_end;
   } curve_point_t;

   // Curve predictor and store of curve points still owed by the block
   class bezier_scoreboard;
      logic [CNT_BITS-1:0] samples_reg;
      coord_t              ctrl_x[3];
      coord_t              ctrl_y[3];
      int unsigned         seg_fill;
      bit                  chain_open;
      bit                  any_sent;
      coord_t              sent_x;
      coord_t              sent_y;
      curve_point_t        owed_q[$];
      int unsigned         mismatches;

      function new();
         samples_reg = SAMPLES_RESET;
         foreach (ctrl_x[i]) begin
            ctrl_x[i] = '0;
            ctrl_y[i] = '0;
         end
         seg_fill   = 0;
         chain_open = 1'b0;
         any_sent   = 1'b0;
         sent_x     = '0;
         sent_y     = '0;
         mismatches = 0;
      endfunction

      function void set_samples(logic [CNT_BITS-1:0] value);
         samples_reg = value;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      function longint clamp(longint v);
         if (v > COORD_HI) return COORD_HI;
         if (v < COORD_LO) return COORD_LO;
         return v;
      endfunction

      // a + (b - a) * t, magnitude rounded to nearest, halves away from zero
      function longint blend(longint a, longint b, longint t);
         longint diff, mag, step;
         diff = b - a;
         mag  = (diff < 0) ? -diff : diff;
         step = (mag >>> FW) * t + (((mag & FRAC_MASK) * t + ROUND_BIT) >>> FW);
         return clamp((diff < 0) ? a - step : a + step);
      endfunction

      function longint curve_at(longint p[4], longint t);
         longint a, b, c, d, e;
         a = blend(p[0], p[1], t);
         b = blend(p[1], p[2], t);
         c = blend(p[2], p[3], t);
         d = blend(a, b, t);
         e = blend(b, c, t);
         return blend(d, e, t);
      endfunction

      function void owe_point(longint x, longint y);
         curve_point_t cp;
         cp.x       = coord_t'(x);
         cp.y       = coord_t'(y);
         cp.run_end = 1'b0;
         owed_q.insert(owed_q.size(), cp);
         sent_x   = cp.x;
         sent_y   = cp.y;
         any_sent = 1'b1;
      endfunction

      // Work out every curve point that one accepted control point causes
      function void note_point(coord_t x, coord_t y, logic last_pt);
         int unsigned size_before;
         longint      n, t;
         longint      px[4];
         longint      py[4];
         size_before = owed_q.size();
         if (!chain_open) begin
            ctrl_x[0]  = x;
            ctrl_y[0]  = y;
            seg_fill   = 1;
            chain_open = 1'b1;
            any_sent   = 1'b0;
         end else if (seg_fill < 3) begin
            ctrl_x[seg_fill] = x;
            ctrl_y[seg_fill] = y;
            seg_fill++;
         end else begin
            n = longint'(samples_reg);
            if (n == 0) n = DEFAULT_SAMPLES;
            if (n > MAX_SAMPLES) n = MAX_SAMPLES;
            for (int i = 0; i < 3; i++) begin
               px[i] = longint'(ctrl_x[i]);
               py[i] = longint'(ctrl_y[i]);
            end
            px[3] = longint'(x);
            py[3] = longint'(y);
            owe_point(px[0], py[0]);
            for (longint k = 0; k < n; k++) begin
               t = ((k <<< FW) + n / 2) / n;
               owe_point(curve_at(px, t), curve_at(py, t));
            end
            ctrl_x[0] = x;
            ctrl_y[0] = y;
            seg_fill  = 1;
         end
         if (last_pt) begin
            if (!any_sent || sent_x != x || sent_y != y)
               owe_point(longint'(x), longint'(y));
            chain_open = 1'b0;
            seg_fill   = 0;
         end
         if (owed_q.size() > size_before)
            owed_q[owed_q.size()-1].run_end = 1'b1;
      endfunction

      function void check_point(coord_t x, coord_t y, logic run_end);
         curve_point_t want;
         if (owed_q.size() == 0) begin
            $error("curve point x=%0d y=%0d run_end=%0b with none outstanding",
                   x, y, run_end);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         if (x !== want.x) begin
            $error("curve_x: expected %0d, got %0d", want.x, x);
            mismatches++;
         end
         if (y !== want.y) begin
            $error("curve_y: expected %0d, got %0d", want.y, y);
            mismatches++;
         end
         if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CNT_BITS-1:0] csr_wdata;

   cbs_req_if #(.COORD_BITS(CW)) req_if ();
   cbs_rsp_if #(.COORD_BITS(CW)) rsp_if ();

   cubic_bezier_sampler #(
      .COORD_BITS(CW),
      .FRAC_BITS (FW)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_if   (req_if),
      .rsp_if   (rsp_if)
   );

   bezier_scoreboard sb = new();

   bit          quiet_spell = 1'b0; // set: neither side idles during this phase
   int unsigned points_sent = 0;
   int unsigned stall_left  = 0;
   int unsigned idle_cycles = 0;

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one; none at all in a quiet spell
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet_spell) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic coord_t pick_coord();
      coord_t v;
      v = coord_t'($urandom);
      case ($urandom_range(0, 9))
         5, 6: v = {{(CW-20){v[19]}}, v[19:0]};   // near the origin
         7:    v = COORD_MAX;
         8:    v = COORD_MIN;
         9:    v = {{(CW-2){v[1]}}, v[1:0]};      // -2 .. 1 LSB
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [CNT_BITS-1:0] pick_samples();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return CNT_BITS'($urandom_range(1, 8));
      if (r < 95) return CNT_BITS'($urandom_range(9, 30));
      return CNT_BITS'($urandom_range(31, 63));
   endfunction

   // Offer one control point, hold it until the transaction completes, then
   // note it. Called at a rising edge; returns at the edge that accepted it.
   task automatic send_point(input coord_t px, input coord_t py, input logic last_pt);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.point_x     <= px;
      req_if.point_y     <= py;
      req_if.final_point <= last_pt;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_point(px, py, last_pt);
      points_sent++;
   endtask

   // One chain of control points, final flag on the last one
   task automatic send_chain(input int unsigned len);
      coord_t px, py;
      bit     flat;
      flat = ($urandom_range(0, 9) == 0);
      px   = pick_coord();
      py   = pick_coord();
      for (int unsigned i = 0; i < len; i++) begin
         if (!flat) begin
            px = pick_coord();
            py = pick_coord();
         end
         // now and then repeat the last curve point sent as the closing point
         if (i == len - 1 && sb.any_sent && $urandom_range(0, 5) == 0) begin
            px = sb.sent_x;
            py = sb.sent_y;
         end
         send_point(px, py, i == len - 1);
      end
   endtask

   function automatic int unsigned pick_chain_len();
      if ($urandom_range(0, 99) < 70) return 3 * $urandom_range(1, 3) + 1;
      return $urandom_range(1, 9);
   endfunction

   // Drop valid and wait for the block to run dry
   task automatic settle_idle(input int unsigned extra);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_samples(input logic [CNT_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_samples(value);
   endtask

   // Result side: check each completed transaction, then decide on a stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_point(rsp_if.curve_x, rsp_if.curve_y, rsp_if.run_end);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Watchdog: end the run if no transaction completes for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[cubic_bezier_sampler] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [CNT_BITS-1:0] fixed_settings[5];
      logic [CNT_BITS-1:0] n;
      int unsigned         setting_no;
      int unsigned         phase_start;
      int unsigned         budget;
      coord_t              rx, ry;

      fixed_settings = '{6'd1, 6'd62, 6'd0, 6'd63, 6'd2};

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.point_x     <= '0;
      req_if.point_y     <= '0;
      req_if.final_point <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run at the reset sample count.
      // Lone final point: a chain of one, always emitted.
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      // Short chain: the partial segment is dropped, only the final point out.
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point('0, '0, 1'b1);
      // Full segment between the coordinate extremes, closing point emitted.
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MIN, COORD_MAX, 1'b0);
      send_point(COORD_MAX, COORD_MIN, 1'b1);
      // Degenerate segment: every sample equals the start, final point withheld.
      rx = 32'sh0001_2345;
      ry = -32'sh0005_4321;
      repeat (3) send_point(rx, ry, 1'b0);
      send_point(rx, ry, 1'b1);
      // Two chained segments sharing an end point.
      repeat (6) send_point(pick_coord(), pick_coord(), 1'b0);
      send_point(pick_coord(), pick_coord(), 1'b1);
      // After a segment, a final point equal to the last curve point sent.
      repeat (4) send_point(pick_coord(), pick_coord(), 1'b0);
      send_point(sb.sent_x, sb.sent_y, 1'b1);
      settle_idle(SETTLE_CYCLES);

      // Random part: one sample count per phase, written only while idle.
      // Fixed extremes first (zero and above-range included), then random.
      setting_no = 0;
      while (points_sent < ITEM_TARGET) begin
         n = (setting_no < 5) ? fixed_settings[setting_no] : pick_samples();
         write_samples(n);
         quiet_spell = ($urandom_range(0, 3) == 0);
         budget      = (n == 0 || n >= 30) ? 12 : 40;
         phase_start = points_sent;
         while (points_sent - phase_start < budget)
            send_chain(pick_chain_len());
         settle_idle(SETTLE_CYCLES);
         setting_no++;
      end

      // Leave room for any stray curve point, then give the verdict
      quiet_spell = 1'b0;
      settle_idle(DRAIN_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[cubic_bezier_sampler] OK");
      else
         $display("[cubic_bezier_sampler] ERROR");
      $finish;
   end

endmodule

### filelist.f
design/cbs_pkg.sv
design/cbs_req_if.sv
design/cbs_rsp_if.sv
design/cbs_lerp.sv
design/cbs_tgen.sv
design/cubic_bezier_sampler.sv
tb/tb_cubic_bezier_sampler.sv
